// ===== hdl/cfsd_pkg.sv =====
// Shared types and constants for the CAN frame stream deframer.
package cfsd_pkg;

  // Parser phase; the unused code is parsed as the header phase.
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1,
    PH_SKIP   = 2'd2
  } phase_t;

  // Input command codes.
  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // Result event codes.
  localparam logic EV_FRAME   = 1'b0;
  localparam logic EV_BAD_LEN = 1'b1;

  // Frame layout.
  localparam int unsigned ID_BYTES     = 4;
  localparam int unsigned HEADER_BYTES = 5;
  localparam int unsigned DLC_LIMIT    = 8;

endpackage

// ===== hdl/can_frame_stream_deframer_top.sv =====
// Byte stream deframer: header, length and payload parsing with a result register.
//
// The input channel (in_valid, in_stall, in_command, in_byte_in) takes one
// transaction per cycle while in_stall is low: a stream byte, or a clear command
// that drops any partly parsed frame (used when the link connects or disconnects).
// Frames are a 4-byte little-endian identifier, a length byte and that many
// data bytes. A result transaction on the output channel carries the event
// kind, identifier, length and payload (first data byte in bits 7:0).
// A length above 8 gives an invalid-length result at the length byte, and
// the parser then drops bytes up to length minus 1 counted from frame start.
// The result of an accepted byte is registered in the output register and
// is valid after the edge that accepts it. Throughput is one byte per cycle
// while in_stall is low, set by the single parse stage feeding the output register.
// in_stall rises only while a result sits in the output register and the
// receiver stalls; the parse state then holds until the result drains.
// Reset (rst_n low, synchronous) returns the parser to the header phase
// and empties the output register.
module can_frame_stream_deframer_top #(
  parameter int unsigned MAX_DATA_LEN = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [7:0]  in_byte_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_event_kind,
  output logic [31:0] out_frame_id,
  output logic [7:0]  out_data_length,
  output logic [63:0] out_payload
);

  localparam int unsigned PL_W = MAX_DATA_LEN * 8;

  cfsd_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic [31:0]      id_r, id_nxt;
  logic [7:0]       len_r, len_nxt;
  logic [PL_W-1:0]  pl_r, pl_nxt;
  logic [7:0]       skip_r, skip_nxt;

  logic        ov_r;
  logic        okind_r, okind_nxt;
  logic [31:0] oid_r, oid_nxt;
  logic [7:0]  olen_r, olen_nxt;
  logic [63:0] opl_r, opl_nxt;
  logic        emit;
  logic        accept;
  logic [3:0]  cnt_inc;

  assign in_stall = ov_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign cnt_inc  = cnt_r + 4'd1;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    pl_nxt    = pl_r;
    skip_nxt  = skip_r;
    emit      = 1'b0;
    okind_nxt = cfsd_pkg::EV_FRAME;
    oid_nxt   = id_r;
    olen_nxt  = len_r;
    opl_nxt   = '0;

    if (in_command == cfsd_pkg::CMD_CLEAR) begin
      phase_nxt = cfsd_pkg::PH_HEADER;
      cnt_nxt   = '0;
      id_nxt    = '0;
      len_nxt   = '0;
      pl_nxt    = '0;
      skip_nxt  = '0;
    end else begin
      unique case (phase_r)
        cfsd_pkg::PH_SKIP: begin
          if (skip_r > 8'd1) begin
            skip_nxt = skip_r - 8'd1;
          end else begin
            phase_nxt = cfsd_pkg::PH_HEADER;
            cnt_nxt   = '0;
            id_nxt    = '0;
            len_nxt   = '0;
            pl_nxt    = '0;
            skip_nxt  = '0;
          end
        end
        cfsd_pkg::PH_DATA: begin
          for (int i = 0; i < MAX_DATA_LEN; i++) begin
            if (cnt_r == 4'(i)) pl_nxt[i*8 +: 8] = pl_r[i*8 +: 8] | in_byte_in;
          end
          cnt_nxt = cnt_inc;
          if ({4'd0, cnt_inc} >= len_r) begin
            emit = 1'b1;
            if (len_r <= 8'(MAX_DATA_LEN)) opl_nxt = 64'(pl_nxt);
            phase_nxt = cfsd_pkg::PH_HEADER;
            cnt_nxt   = '0;
            id_nxt    = '0;
            len_nxt   = '0;
            pl_nxt    = '0;
            skip_nxt  = '0;
          end
        end
        default: begin
          phase_nxt = cfsd_pkg::PH_HEADER;
          if (cnt_r < 4'(cfsd_pkg::ID_BYTES)) begin
            for (int i = 0; i < cfsd_pkg::ID_BYTES; i++) begin
              if (cnt_r == 4'(i)) id_nxt[i*8 +: 8] = id_r[i*8 +: 8] | in_byte_in;
            end
            cnt_nxt = cnt_inc;
          end else begin
            olen_nxt = in_byte_in;
            cnt_nxt  = '0;
            pl_nxt   = '0;
            if (in_byte_in > 8'(cfsd_pkg::DLC_LIMIT)) begin
              // Drop the rest of the oversized frame; at least three bytes remain.
              emit      = 1'b1;
              okind_nxt = cfsd_pkg::EV_BAD_LEN;
              skip_nxt  = in_byte_in - 8'(cfsd_pkg::HEADER_BYTES + 1);
              id_nxt    = '0;
              len_nxt   = '0;
              phase_nxt = cfsd_pkg::PH_SKIP;
            end else if (in_byte_in == 8'd0) begin
              emit     = 1'b1;
              id_nxt   = '0;
              len_nxt  = '0;
              skip_nxt = '0;
            end else begin
              len_nxt   = in_byte_in;
              phase_nxt = cfsd_pkg::PH_DATA;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= cfsd_pkg::PH_HEADER;
      cnt_r   <= '0;
      id_r    <= '0;
      len_r   <= '0;
      pl_r    <= '0;
      skip_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      pl_r    <= pl_nxt;
      skip_r  <= skip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (accept && emit) begin
      ov_r <= 1'b1;
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      okind_r <= okind_nxt;
      oid_r   <= oid_nxt;
      olen_r  <= olen_nxt;
      opl_r   <= opl_nxt;
    end
  end

  assign out_valid       = ov_r;
  assign out_event_kind  = okind_r;
  assign out_frame_id    = oid_r;
  assign out_data_length = olen_r;
  assign out_payload     = opl_r;

endmodule

// ===== hdl/cfsd_checker.sv =====
// Port-level assertions for the deframer top level, with their bind.
module cfsd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_event_kind,
  input logic [31:0] out_frame_id,
  input logic [7:0]  out_data_length,
  input logic [63:0] out_payload
);

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frame_id) &&
      $stable(out_payload) && $stable(out_data_length) && $stable(out_event_kind))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result blocked");

  a_bad_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == cfsd_pkg::EV_BAD_LEN |->
      out_payload == 64'd0 && out_data_length > 8'(cfsd_pkg::DLC_LIMIT))
    else $error("invalid-length result malformed");

  a_frame_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == cfsd_pkg::EV_FRAME |->
      out_data_length <= 8'(cfsd_pkg::DLC_LIMIT) &&
      (out_data_length != 8'd0 || out_payload == 64'd0))
    else $error("frame result malformed");

endmodule

bind can_frame_stream_deframer_top cfsd_checker u_cfsd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_event_kind  (out_event_kind),
  .out_frame_id    (out_frame_id),
  .out_data_length (out_data_length),
  .out_payload     (out_payload)
);
